>>> rtl/core/bmaf_pkg.sv
// Shared types and constants for the banded moving-average filter.
// Used by bmaf_update and banded_moving_average_filter; no dependencies.
package bmaf_pkg;

    // Window length in samples. It must be a power of two between 2 and 256,
    // because the divide is done as a rounding-corrected arithmetic shift.
    localparam int WINDOW     = 16;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int WIN_SHIFT  = $clog2(WINDOW);

    // Sample and average width in millivolts, and the saturation limit.
    localparam int MV_W       = 12;
    localparam int TDATA_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam logic [MV_W-1:0] MV_MAX = 12'd4095;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BAND_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BAND_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BAND_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BAND_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_CLAMP_VALUE = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [MV_W-1:0] RST_UPPER_BAND_LOW    = 12'd2500;
    localparam logic [MV_W-1:0] RST_UPPER_BAND_HIGH   = 12'd2700;
    localparam logic [MV_W-1:0] RST_LOWER_BAND_LOW    = 12'd700;
    localparam logic [MV_W-1:0] RST_LOWER_BAND_HIGH   = 12'd1100;
    localparam logic [MV_W-1:0] RST_LOWER_CLAMP_VALUE = 12'd900;

    // Band settings handed to the update datapath.
    typedef struct packed {
        logic [MV_W-1:0] upper_band_low;
        logic [MV_W-1:0] upper_band_high;
        logic [MV_W-1:0] lower_band_low;
        logic [MV_W-1:0] lower_band_high;
        logic [MV_W-1:0] lower_clamp_value;
    } band_cfg_t;

endpackage

>>> rtl/core/bmaf_update.sv
// Combinational average update: difference, divide by the window, saturate
// and band clamp. Depends on bmaf_pkg.
module bmaf_update (
    input  logic [bmaf_pkg::MV_W-1:0] sample_mv,
    input  logic [bmaf_pkg::MV_W-1:0] oldest_mv,
    input  logic [bmaf_pkg::MV_W-1:0] average_mv,
    input  bmaf_pkg::band_cfg_t       cfg,
    output logic [bmaf_pkg::MV_W-1:0] new_average_mv
);
    import bmaf_pkg::*;

    logic signed [MV_W:0]   diff;
    logic signed [MV_W:0]   biased;
    logic signed [MV_W:0]   quotient;
    logic signed [MV_W+1:0] sum;
    logic [MV_W-1:0]        sat;

    // Signed difference, divided by the window with truncation toward zero.
    always_comb
    begin
        diff     = $signed({1'b0, sample_mv}) - $signed({1'b0, oldest_mv});
        biased   = diff[MV_W] ? diff + $signed((MV_W+1)'(WINDOW - 1)) : diff;
        quotient = biased >>> WIN_SHIFT;
        sum      = $signed({2'b00, average_mv}) + $signed({quotient[MV_W], quotient});
    end

    // Saturate to the millivolt range.
    always_comb
    begin
        priority if (sum[MV_W+1])
            sat = '0;
        else if (sum[MV_W])
            sat = MV_MAX;
        else
            sat = sum[MV_W-1:0];
    end

    // Band clamp; the upper band is tested first.
    always_comb
    begin
        priority if (sat > cfg.upper_band_low && sat < cfg.upper_band_high)
            new_average_mv = cfg.upper_band_low;
        else if (sat < cfg.lower_band_high && sat > cfg.lower_band_low)
            new_average_mv = cfg.lower_clamp_value;
        else
            new_average_mv = sat;
    end

endmodule

>>> rtl/core/banded_moving_average_filter.sv
// Banded moving-average filter top level: stream ports, sample window,
// configuration registers and output register. Depends on bmaf_pkg, bmaf_update.
// Each item passes through the input register and then the result register.
// Throughput: one sample per cycle while the output is not stalled; the update of the
// average from one item to the next is the combinational path through bmaf_update.
// Reset (rst_n, asynchronous, active low) clears the window, index and average,
// and loads the band registers with their default values. No clearing pass.
module banded_moving_average_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream; s_tdata: [11:0] sample_mv, [15:12] zero.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmaf_pkg::TDATA_W-1:0]      s_tdata,
    // Output stream; m_tdata: [11:0] average_mv, [15:12] zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmaf_pkg::TDATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmaf_pkg::MV_W-1:0]         cfg_data
);
    import bmaf_pkg::*;

    band_cfg_t              cfg_reg;
    logic [MV_W-1:0]        window_reg [WINDOW];
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [IDX_W-1:0]       wr_idx_next;
    logic [MV_W-1:0]        avg_reg;
    logic [MV_W-1:0]        avg_next;
    logic                   in_valid_reg;
    logic [MV_W-1:0]        in_sample_reg;
    logic                   out_valid_reg;
    logic [MV_W-1:0]        out_data_reg;
    logic                   advance;
    logic                   s_accept;

    // The item in the input register moves on when the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(TDATA_W - MV_W){1'b0}}, out_data_reg};

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_band_low    <= RST_UPPER_BAND_LOW;
            cfg_reg.upper_band_high   <= RST_UPPER_BAND_HIGH;
            cfg_reg.lower_band_low    <= RST_LOWER_BAND_LOW;
            cfg_reg.lower_band_high   <= RST_LOWER_BAND_HIGH;
            cfg_reg.lower_clamp_value <= RST_LOWER_CLAMP_VALUE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_UPPER_BAND_LOW:    cfg_reg.upper_band_low    <= cfg_data;
                REG_UPPER_BAND_HIGH:   cfg_reg.upper_band_high   <= cfg_data;
                REG_LOWER_BAND_LOW:    cfg_reg.lower_band_low    <= cfg_data;
                REG_LOWER_BAND_HIGH:   cfg_reg.lower_band_high   <= cfg_data;
                REG_LOWER_CLAMP_VALUE: cfg_reg.lower_clamp_value <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_sample_reg <= s_tdata[MV_W-1:0];
        end
    end

    // Average update for the item in the input register.
    bmaf_update u_update (
        .sample_mv      (in_sample_reg),
        .oldest_mv      (window_reg[wr_idx_reg]),
        .average_mv     (avg_reg),
        .cfg            (cfg_reg),
        .new_average_mv (avg_next)
    );

    assign wr_idx_next = (wr_idx_reg == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_reg + 1'b1;

    // Window, write index and running average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            wr_idx_reg <= '0;
            avg_reg    <= '0;
        end
        else if (advance)
        begin
            window_reg[wr_idx_reg] <= in_sample_reg;
            wr_idx_reg             <= wr_idx_next;
            avg_reg                <= avg_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= avg_next;
        end
    end

    // The write index wraps at the end of the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && wr_idx_reg == IDX_W'(WINDOW - 1) |=> wr_idx_reg == '0)
        else $error("write index did not wrap");

    // A fresh result matches the stored running average.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid && m_tdata[MV_W-1:0] == avg_reg)
        else $error("result differs from stored average");

    // The input side only stalls when both stages hold an item and the output waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    // Write index and average change only when an item is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(avg_reg) && $stable(wr_idx_reg))
        else $error("state changed without an item");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the banded moving-average filter: directed rows, then
// randomised phases with random stream stalls. Depends on bmaf_pkg and the filter RTL.
module testbench;
    import bmaf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int SETTLE      = 8;
    localparam int MAX_REPORTS = 10;
    localparam int PLAN_ROWS   = 40;

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [MV_W-1:0]      value;
        logic                 typed;
        logic [MV_W-1:0]      average;
    } plan_row_t;

    typedef struct packed {
        logic            typed;
        logic [MV_W-1:0] average;
    } fixed_avg_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MV_W-1:0]      cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_ready;

    // Predictor state: sample window, oldest slot, running average and band settings.
    logic [MV_W-1:0]  win_mem [WINDOW];
    logic [IDX_W-1:0] oldest_slot;
    logic [MV_W-1:0]  avg_state;
    band_cfg_t        bands;

    logic [MV_W-1:0]  average_q [$];
    fixed_avg_t       fixed_q [$];
    int               fail_count = 0;
    int unsigned      cycles = 0;
    bit               steady = 1'b0;

    // Directed rows. Typed averages are only given where they follow directly from reset.
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, '0, 12'd0,    1'b1, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 12'd255},
        '{ROW_SAMPLE, '0, 12'd1,    1'b1, 12'd255},
        '{ROW_SAMPLE, '0, 12'd15,   1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd16,   1'b0, 12'd0},
        // Both bands cover almost everything; the upper band must win.
        '{ROW_WRITE,  REG_UPPER_BAND_LOW,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE,  REG_UPPER_BAND_HIGH,   12'd4095, 1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_LOW,    12'd0,    1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_HIGH,   12'd4095, 1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_CLAMP_VALUE, 12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd2048, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd0,    1'b0, 12'd0},
        // Inverted upper band never clamps; clamp value sits on the lower band's upper edge, just outside it.
        '{ROW_WRITE,  REG_UPPER_BAND_LOW,    12'd4095, 1'b0, 12'd0},
        '{ROW_WRITE,  REG_UPPER_BAND_HIGH,   12'd0,    1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd3000, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        // Writes past the register list, then an empty lower band.
        '{ROW_WRITE,  REG_SPARE_FIRST,       12'hAAA,  1'b0, 12'd0},
        '{ROW_WRITE,  REG_SPARE_LAST,        12'h555,  1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_LOW,    12'd4095, 1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_HIGH,   12'd4095, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd0,    1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd2,    1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 12'd0},
        // Back to the default bands.
        '{ROW_WRITE,  REG_UPPER_BAND_LOW,    RST_UPPER_BAND_LOW,    1'b0, 12'd0},
        '{ROW_WRITE,  REG_UPPER_BAND_HIGH,   RST_UPPER_BAND_HIGH,   1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_LOW,    RST_LOWER_BAND_LOW,    1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_BAND_HIGH,   RST_LOWER_BAND_HIGH,   1'b0, 12'd0},
        '{ROW_WRITE,  REG_LOWER_CLAMP_VALUE, RST_LOWER_CLAMP_VALUE, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd2600, 1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd900,  1'b0, 12'd0},
        '{ROW_SAMPLE, '0, 12'd1000, 1'b0, 12'd0}
    };

    banded_moving_average_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls at random unless a steady phase is running.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 17);
    end

    // Puts the predictor into its state after reset.
    task automatic clear_model();
        for (int i = 0; i < WINDOW; i++)
        begin
            win_mem[i] = '0;
        end
        oldest_slot             = '0;
        avg_state               = '0;
        bands.upper_band_low    = RST_UPPER_BAND_LOW;
        bands.upper_band_high   = RST_UPPER_BAND_HIGH;
        bands.lower_band_low    = RST_LOWER_BAND_LOW;
        bands.lower_band_high   = RST_LOWER_BAND_HIGH;
        bands.lower_clamp_value = RST_LOWER_CLAMP_VALUE;
    endtask

    // Advances the window by one sample and returns the band-clamped average.
    function automatic logic [MV_W-1:0] next_average(input logic [MV_W-1:0] sample);
        int              delta;
        int              sum;
        logic [MV_W-1:0] result;
        delta = int'(sample) - int'(win_mem[oldest_slot]);
        // Integer division truncates toward zero, as the filter's divide must.
        sum = int'(avg_state) + delta / WINDOW;
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > int'(MV_MAX))
        begin
            sum = int'(MV_MAX);
        end
        result = sum[MV_W-1:0];
        // The upper band is tested first; a forced value is not tested again.
        if (result > bands.upper_band_low && result < bands.upper_band_high)
        begin
            result = bands.upper_band_low;
        end
        else if (result < bands.lower_band_high && result > bands.lower_band_low)
        begin
            result = bands.lower_clamp_value;
        end
        avg_state            = result;
        win_mem[oldest_slot] = sample;
        oldest_slot          = oldest_slot + 1'b1;
        return result;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", what);
        end
    endtask

    // Watches all three channels: register writes, accepted samples and results.
    always @(posedge clk)
    begin : watch
        fixed_avg_t      hint;
        logic [MV_W-1:0] predicted;
        logic [MV_W-1:0] wanted;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPPER_BAND_LOW:    bands.upper_band_low    = cfg_data;
                REG_UPPER_BAND_HIGH:   bands.upper_band_high   = cfg_data;
                REG_LOWER_BAND_LOW:    bands.lower_band_low    = cfg_data;
                REG_LOWER_BAND_HIGH:   bands.lower_band_high   = cfg_data;
                REG_LOWER_CLAMP_VALUE: bands.lower_clamp_value = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            hint = '0;
            if (fixed_q.size() != 0)
            begin
                hint = fixed_q.pop_front();
            end
            predicted = next_average(s_tdata[MV_W-1:0]);
            average_q.push_back(hint.typed ? hint.average : predicted);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (average_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result transaction: average_mv %0d",
                                       m_tdata[MV_W-1:0]));
            end
            else
            begin
                wanted = average_q.pop_front();
                if (m_tdata[MV_W-1:0] !== wanted)
                begin
                    note_failure($sformatf("average_mv mismatch: expected %0d, got %0d",
                                           wanted, m_tdata[MV_W-1:0]));
                end
            end
        end
    end

    // Offers one sample, with random gaps in front of it, and waits for the transaction.
    task automatic push_sample(input logic [MV_W-1:0] sample, input logic typed,
                               input logic [MV_W-1:0] average);
        fixed_avg_t hint;
        while (!steady && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'($urandom);
            @(posedge clk);
        end
        hint.typed   = typed;
        hint.average = average;
        fixed_q.push_back(hint);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(sample);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds the sender back until every expected result has arrived. The first wait
    // lets the watcher record a sample accepted at the edge the caller returned on.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (average_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write transaction; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [MV_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // A band edge near the working level, or now and then one of the extremes.
    function automatic logic [MV_W-1:0] pick_edge(input int level);
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = int'(MV_MAX);
            default: v = level + int'($urandom_range(800)) - 400;
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > int'(MV_MAX))
        begin
            v = int'(MV_MAX);
        end
        return v[MV_W-1:0];
    endfunction

    initial
    begin : stimulus
        bit              last_was_write;
        int              level;
        int              spread;
        int              v;
        int              r;
        logic [MV_W-1:0] sample;
        clear_model();
        last_was_write = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (int row = 0; row < PLAN_ROWS; row++)
        begin
            if (plan[row].kind == ROW_WRITE)
            begin
                if (!last_was_write)
                begin
                    drain_results();
                end
                write_reg(plan[row].index, plan[row].value);
                last_was_write = 1'b1;
            end
            else
            begin
                if (last_was_write)
                begin
                    cfg_valid <= 1'b0;
                end
                push_sample(plan[row].value, plan[row].typed, plan[row].average);
                last_was_write = 1'b0;
            end
        end

        // Random phases: new bands around a working level, then samples near that level.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            level  = $urandom_range(4095);
            spread = $urandom_range(600, 10);
            steady = (phase == 3);
            for (r = int'(REG_UPPER_BAND_LOW); r <= int'(REG_LOWER_CLAMP_VALUE); r++)
            begin
                if ($urandom_range(9) < 7)
                begin
                    write_reg(r[CFG_IDX_W-1:0], pick_edge(level));
                end
            end
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                          MV_W'($urandom));
            end
            cfg_valid <= 1'b0;
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                case ($urandom_range(9))
                    0:       sample = $urandom_range(1) ? MV_MAX : '0;
                    1:       sample = MV_W'($urandom);
                    default:
                    begin
                        v = level + int'($urandom_range(2 * spread)) - spread;
                        if (v < 0)
                        begin
                            v = 0;
                        end
                        if (v > int'(MV_MAX))
                        begin
                            v = int'(MV_MAX);
                        end
                        sample = v[MV_W-1:0];
                    end
                endcase
                push_sample(sample, 1'b0, '0);
            end
        end
        steady = 1'b0;

        // Wait for the last results, then give the verdict.
        drain_results();
        if (fail_count == 0 && average_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bmaf_pkg.sv
rtl/core/bmaf_update.sv
rtl/core/banded_moving_average_filter.sv
sim/testbench.sv
